// File: src/trdl_pkg.sv
// ----------------------------------------------------------------------------
// trdl_pkg
// Shared types, constants and handshake structs for the tag restore lookup.
// ----------------------------------------------------------------------------
`default_nettype none

package trdl_pkg;

   // Table geometry.
   localparam int KEY_ENTRIES    = 4096;
   localparam int VALUES_PER_KEY = 4;
   localparam int TAG_ENTRIES    = 4096;
   localparam int VALUE_ENTRIES  = KEY_ENTRIES * VALUES_PER_KEY;
   localparam int KEY_SHIFT      = 12;
   localparam int PLAIN_FACTOR   = 2;

   localparam int KEY_AW  = $clog2(KEY_ENTRIES);
   localparam int VAL_AW  = $clog2(VALUE_ENTRIES);
   localparam int TAG_AW  = $clog2(TAG_ENTRIES);
   localparam int SRCH_W  = $clog2(KEY_ENTRIES + 1);
   localparam int CNT_W   = $clog2(VALUES_PER_KEY + 1);

   // Field widths.
   localparam int TAG_COUNT_W = 11;
   localparam int KEY_COUNT_W = 13;
   localparam int CSR_DATA_W  = 13;
   localparam int CHAR_W      = 21;
   localparam int TAG_W       = 12;
   localparam int WORD_W      = 32;
   localparam int FT_W        = 8;

   localparam logic [TAG_COUNT_W-1:0] TAG_COUNT_RESET = 11'd46;
   localparam logic [KEY_COUNT_W-1:0] KEY_COUNT_RESET = 13'd0;

   // Register indexes.
   localparam logic CSR_TAG_COUNT = 1'b0;
   localparam logic CSR_KEY_COUNT = 1'b1;

   // Request types.
   localparam logic [1:0] REQ_QUERY    = 2'd0;
   localparam logic [1:0] REQ_LOAD_KEY = 2'd1;
   localparam logic [1:0] REQ_LOAD_VAL = 2'd2;
   localparam logic [1:0] REQ_LOAD_FT  = 2'd3;

   // Result kinds.
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_WORD = 1'b1;

   // Output source select.
   localparam logic OUT_SEL_CHAR = 1'b0;
   localparam logic OUT_SEL_WORD = 1'b1;

   typedef struct packed {
      logic [1:0]        req_type;
      logic [CHAR_W-1:0] char_code;
      logic [TAG_W-1:0]  tag_in;
      logic              use_dictionary;
      logic [13:0]       load_index;
      logic [WORD_W-1:0] load_data;
   } req_item_type;

   typedef struct packed {
      logic              result_kind;
      logic [CHAR_W-1:0] char_out;
      logic [TAG_W-1:0]  tag_out;
      logic [WORD_W-1:0] value_word;
      logic              last;
   } rsp_item_type;

   typedef struct packed {
      logic accept;
      logic search_init;
      logic key_rd;
      logic key_step;
      logic val_init;
      logic val_rd;
      logic val_take;
      logic out_load;
      logic out_sel;
      logic out_last;
   } cmd_type;

   typedef struct packed {
      logic is_query;
      logic plain;
      logic use_dic;
      logic search_live;
      logic key_eq;
      logic word_zero;
      logic pend_valid;
      logic cnt_done;
      logic out_free;
   } status_type;

endpackage

`default_nettype wire

// File: src/trdl_ctrl.sv
// ----------------------------------------------------------------------------
// trdl_ctrl
// Sequencer for queries: plain check, binary search probes and value reads.
// ----------------------------------------------------------------------------
`default_nettype none

module trdl_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire trdl_pkg::status_type  status,
   output trdl_pkg::cmd_type          cmd
);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_DECIDE = 3'd1;
   localparam logic [2:0] S_PROBE  = 3'd2;
   localparam logic [2:0] S_CMP    = 3'd3;
   localparam logic [2:0] S_VRD    = 3'd4;
   localparam logic [2:0] S_VCHK   = 3'd5;
   localparam logic [2:0] S_VLAST  = 3'd6;
   localparam logic [2:0] S_EMIT   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_stall = (state_ff != S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               if (status.is_query) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            if (status.plain || !status.use_dic) begin
               state_in = S_EMIT;
            end else begin
               cmd.search_init = 1'b1;
               state_in        = S_PROBE;
            end
         end
         S_PROBE: begin
            if (status.search_live) begin
               cmd.key_rd = 1'b1;
               state_in   = S_CMP;
            end else begin
               state_in = S_EMIT;
            end
         end
         S_CMP: begin
            cmd.key_step = 1'b1;
            if (status.key_eq) begin
               cmd.val_init = 1'b1;
               state_in     = S_VRD;
            end else begin
               state_in = S_PROBE;
            end
         end
         S_VRD: begin
            cmd.val_rd = 1'b1;
            state_in   = S_VCHK;
         end
         S_VCHK: begin
            // A word is only sent once the following word is known, so that
            // the last flag can be set on it.
            if (status.word_zero) begin
               if (!status.pend_valid) begin
                  state_in = S_IDLE;
               end else if (status.out_free) begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = trdl_pkg::OUT_SEL_WORD;
                  cmd.out_last = 1'b1;
                  state_in     = S_IDLE;
               end
            end else if (!status.pend_valid || status.out_free) begin
               cmd.out_load = status.pend_valid;
               cmd.out_sel  = trdl_pkg::OUT_SEL_WORD;
               cmd.val_take = 1'b1;
               state_in     = status.cnt_done ? S_VLAST : S_VRD;
            end
         end
         S_VLAST: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = trdl_pkg::OUT_SEL_WORD;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_EMIT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = trdl_pkg::OUT_SEL_CHAR;
               cmd.out_last = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   a_load_stays_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.accept && !status.is_query) |=> (state_ff == S_IDLE))
      else $error("load request left the idle state");

   a_vlast_has_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_VLAST) |-> status.pend_valid)
      else $error("final word state without a pending word");

   a_probe_live: assert property (@(posedge clock) disable iff (reset)
      cmd.key_rd |-> status.search_live)
      else $error("key probe issued on an empty search range");

   a_load_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> status.out_free)
      else $error("output loaded while a stalled result is held");

`default_nettype wire
endmodule

// File: src/trdl_dp.sv
// ----------------------------------------------------------------------------
// trdl_dp
// Datapath: registers, the three tables, search bounds and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module trdl_dp (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   csr_we,
   input  wire logic                                   csr_index,
   input  wire logic [trdl_pkg::CSR_DATA_W-1:0]        csr_wdata,
   input  wire trdl_pkg::req_item_type                 req_data,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output trdl_pkg::rsp_item_type                      rsp_data,
   input  wire trdl_pkg::cmd_type                      cmd,
   output trdl_pkg::status_type                        status
);

   // Configuration registers.
   logic [trdl_pkg::TAG_COUNT_W-1:0] tag_count_ff;
   logic [trdl_pkg::KEY_COUNT_W-1:0] key_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_count_ff <= trdl_pkg::TAG_COUNT_RESET;
         key_count_ff <= trdl_pkg::KEY_COUNT_RESET;
      end else if (csr_we) begin
         case (csr_index)
            trdl_pkg::CSR_TAG_COUNT: tag_count_ff <= csr_wdata[trdl_pkg::TAG_COUNT_W-1:0];
            trdl_pkg::CSR_KEY_COUNT: key_count_ff <= csr_wdata[trdl_pkg::KEY_COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   // Query registers, captured with the request.
   logic [trdl_pkg::CHAR_W-1:0] char_ff;
   logic [trdl_pkg::TAG_W-1:0]  tag_ff;
   logic                        use_dic_ff;
   logic [trdl_pkg::WORD_W-1:0] key_ff;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         char_ff    <= req_data.char_code;
         tag_ff     <= req_data.tag_in;
         use_dic_ff <= req_data.use_dictionary;
         key_ff     <= trdl_pkg::WORD_W'({req_data.char_code, req_data.tag_in});
      end
   end

   // Table writes happen on the accepting edge; out-of-range loads are dropped.
   logic key_we;
   logic val_we;
   logic ft_we;

   assign key_we = cmd.accept && (req_data.req_type == trdl_pkg::REQ_LOAD_KEY)
                   && (32'(req_data.load_index) < 32'(trdl_pkg::KEY_ENTRIES));
   assign val_we = cmd.accept && (req_data.req_type == trdl_pkg::REQ_LOAD_VAL)
                   && (32'(req_data.load_index) < 32'(trdl_pkg::VALUE_ENTRIES));
   assign ft_we  = cmd.accept && (req_data.req_type == trdl_pkg::REQ_LOAD_FT)
                   && (32'(req_data.load_index) < 32'(trdl_pkg::TAG_ENTRIES));

   // First-tag table; read with every accepted request, used by the query.
   logic [trdl_pkg::FT_W-1:0] ft_mem [trdl_pkg::TAG_ENTRIES];
   logic [trdl_pkg::FT_W-1:0] ft_rd_ff;

   always_ff @(posedge clock) begin
      if (ft_we) begin
         ft_mem[trdl_pkg::TAG_AW'(req_data.load_index)] <= req_data.load_data[trdl_pkg::FT_W-1:0];
      end
      if (cmd.accept) begin
         ft_rd_ff <= ft_mem[trdl_pkg::TAG_AW'(req_data.tag_in)];
      end
   end

   // Search bounds over the sorted key table.
   logic [trdl_pkg::SRCH_W-1:0] lo_ff;
   logic [trdl_pkg::SRCH_W-1:0] hi_ff;
   logic [trdl_pkg::SRCH_W-1:0] mid_ff;
   logic [trdl_pkg::SRCH_W-1:0] mid;
   logic [trdl_pkg::SRCH_W-1:0] hi_init;
   logic [trdl_pkg::WORD_W-1:0] key_rd_ff;
   logic [trdl_pkg::WORD_W-1:0] key_mem [trdl_pkg::KEY_ENTRIES];
   logic                        key_lt;

   assign mid     = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign hi_init = (32'(key_count_ff) > 32'(trdl_pkg::KEY_ENTRIES))
                    ? trdl_pkg::SRCH_W'(trdl_pkg::KEY_ENTRIES)
                    : trdl_pkg::SRCH_W'(key_count_ff);
   assign key_lt  = key_ff < key_rd_ff;

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[trdl_pkg::KEY_AW'(req_data.load_index)] <= req_data.load_data;
      end
      if (cmd.key_rd) begin
         key_rd_ff <= key_mem[mid[trdl_pkg::KEY_AW-1:0]];
         mid_ff    <= mid;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.search_init) begin
         lo_ff <= '0;
         hi_ff <= hi_init;
      end else if (cmd.key_step && (key_ff != key_rd_ff)) begin
         if (key_lt) begin
            hi_ff <= mid_ff;
         end else begin
            lo_ff <= mid_ff + trdl_pkg::SRCH_W'(1);
         end
      end
   end

   // Value words of a hit, read one per step with one word held back.
   logic [trdl_pkg::WORD_W-1:0] val_mem [trdl_pkg::VALUE_ENTRIES];
   logic [trdl_pkg::WORD_W-1:0] val_rd_ff;
   logic [trdl_pkg::VAL_AW-1:0] val_addr_ff;
   logic [trdl_pkg::CNT_W-1:0]  cnt_ff;
   logic [trdl_pkg::WORD_W-1:0] pend_ff;
   logic                        pend_valid_ff;

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[trdl_pkg::VAL_AW'(req_data.load_index)] <= req_data.load_data;
      end
      if (cmd.val_rd) begin
         val_rd_ff <= val_mem[val_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.val_init) begin
         val_addr_ff <= trdl_pkg::VAL_AW'(32'(mid_ff[trdl_pkg::KEY_AW-1:0])
                                          * trdl_pkg::VALUES_PER_KEY);
         cnt_ff      <= '0;
      end else if (cmd.val_rd) begin
         val_addr_ff <= val_addr_ff + trdl_pkg::VAL_AW'(1);
         cnt_ff      <= cnt_ff + trdl_pkg::CNT_W'(1);
      end
      if (cmd.val_take) begin
         pend_ff <= val_rd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || cmd.val_init) begin
         pend_valid_ff <= 1'b0;
      end else if (cmd.val_take) begin
         pend_valid_ff <= 1'b1;
      end
   end

   // Result register.
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   trdl_pkg::rsp_item_type rsp_data_ff;
   trdl_pkg::rsp_item_type rsp_data_in;
   logic                   plain;
   logic [trdl_pkg::TAG_W-1:0] ft_tag;

   assign plain  = 13'(tag_ff) <= 13'(32'(tag_count_ff) * trdl_pkg::PLAIN_FACTOR);
   assign ft_tag = (32'(tag_ff) < 32'(trdl_pkg::TAG_ENTRIES))
                   ? trdl_pkg::TAG_W'(ft_rd_ff) : '0;

   always_comb begin
      rsp_data_in = '0;
      case (cmd.out_sel)
         trdl_pkg::OUT_SEL_CHAR: begin
            rsp_data_in.result_kind = trdl_pkg::KIND_CHAR;
            rsp_data_in.char_out    = char_ff;
            rsp_data_in.tag_out     = plain ? tag_ff : ft_tag;
         end
         trdl_pkg::OUT_SEL_WORD: begin
            rsp_data_in.result_kind = trdl_pkg::KIND_WORD;
            rsp_data_in.value_word  = pend_ff;
         end
         default: ;
      endcase
      rsp_data_in.last = cmd.out_last;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign status.is_query    = (req_data.req_type == trdl_pkg::REQ_QUERY);
   assign status.plain       = plain;
   assign status.use_dic     = use_dic_ff;
   assign status.search_live = lo_ff < hi_ff;
   assign status.key_eq      = (key_ff == key_rd_ff);
   assign status.word_zero   = (val_rd_ff == '0);
   assign status.pend_valid  = pend_valid_ff;
   assign status.cnt_done    = (cnt_ff == trdl_pkg::CNT_W'(trdl_pkg::VALUES_PER_KEY));
   assign status.out_free    = !rsp_valid_ff || !rsp_stall;

   a_held_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("stalled result was lost or changed");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cmd.val_rd |-> (32'(cnt_ff) < 32'(trdl_pkg::VALUES_PER_KEY)))
      else $error("value read past the per-key limit");

   a_word_nonzero: assert property (@(posedge clock) disable iff (reset)
      (cmd.out_load && (cmd.out_sel == trdl_pkg::OUT_SEL_WORD)) |-> (pend_ff != '0))
      else $error("zero value word sent as a result");

`default_nettype wire
endmodule

// File: src/tag_restore_dictionary_lookup.sv
// Timing: a load request is written on its accepting edge; a plain or first-tag query passes
// through the decide and emit states to the result register; a dictionary query makes search
// probes (at most 13 over 4096 keys, one key-table read each) and then reads its value words.
// Throughput: loads one per cycle while no query is in progress; queries one at a time.
// Reset: control and configuration (tag_count 46, key_count 0) clear; tables keep contents.
// ----------------------------------------------------------------------------
// tag_restore_dictionary_lookup
// Restores output tags through a first-tag table or a sorted key dictionary.
// ----------------------------------------------------------------------------
`default_nettype none

module tag_restore_dictionary_lookup (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_we,
   input  wire logic                            csr_index,
   input  wire logic [trdl_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire trdl_pkg::req_item_type          req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output trdl_pkg::rsp_item_type               rsp_data
);

   trdl_pkg::cmd_type    cmd;
   trdl_pkg::status_type status;

   trdl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   trdl_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .cmd       (cmd),
      .status    (status)
   );

`default_nettype wire
endmodule
